// File: hw/rtl/obct_pkg.sv
// Shared constants and the arctangent table for the oriented box collision test.
package obct_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int TRIG_WIDTH    = 16;
    localparam int CORDIC_ITERS  = 16;
    localparam int CORDIC_XW     = 18;
    localparam int CORDIC_ZW     = 32;
    localparam int CORDIC_STAGES = CORDIC_ITERS + 1;
    localparam int TEST_STAGES   = 5;
    localparam int PIPE_STAGES   = 1 + CORDIC_STAGES + TEST_STAGES;

    // Start vector of the rotation; it absorbs the CORDIC gain.
    localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 18'sd19898;
    localparam logic signed [CORDIC_XW-1:0] TRIG_MAX  = 18'sd32767;

    // Quadrant codes taken from the top two angle bits.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Arctangent of 2^-i with 2^32 units per turn.
    function automatic logic signed [CORDIC_ZW-1:0] cordic_atan(input logic [3:0] idx);
        logic signed [CORDIC_ZW-1:0] r;
        unique case (idx)
            4'd0:  r = 32'sh20000000;
            4'd1:  r = 32'sh12E4051E;
            4'd2:  r = 32'sh09FB385B;
            4'd3:  r = 32'sh051111D4;
            4'd4:  r = 32'sh028B0D43;
            4'd5:  r = 32'sh0145D7E1;
            4'd6:  r = 32'sh00A2F61E;
            4'd7:  r = 32'sh00517C55;
            4'd8:  r = 32'sh0028BE53;
            4'd9:  r = 32'sh00145F2F;
            4'd10: r = 32'sh000A2F98;
            4'd11: r = 32'sh000517CC;
            4'd12: r = 32'sh00028BE6;
            4'd13: r = 32'sh000145F3;
            4'd14: r = 32'sh0000A2FA;
            default: r = 32'sh0000517D;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/oriented_box_collision_test_top.sv
// Top level of the oriented box collision test pipeline.
//
//  channel | direction | tdata                       | tuser
//  s_      | in        | box A, box B / circle       | mode
//  m_      | out       | collide                     | -
//
// One transaction is accepted per cycle while the pipeline is not held. The pipeline
// holds 23 register stages: an input stage, the 16-iteration CORDIC pipeline (plus its
// output register) that makes the sines and cosines, and five projection and compare
// stages.
// aresetn clears only the valid bits. When m_tready is low with a result
// waiting, the whole pipeline holds and s_tready drops; nothing is lost.
module oriented_box_collision_test_top #(
    parameter int COORD_WIDTH = obct_pkg::COORD_WIDTH,
    parameter int ANGLE_WIDTH = obct_pkg::ANGLE_WIDTH,
    localparam int IN_BITS       = 9 * COORD_WIDTH - 5 + 2 * ANGLE_WIDTH,
    localparam int S_TDATA_WIDTH = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // a_center_x, a_center_y, a_half_x, a_half_y, a_angle, b_center_x,
    // b_center_y, b_half_x, b_half_y, b_angle, circle_radius, zero fill
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,
    // mode
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // collide, zero fill
    output logic [7:0]               m_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int HS = CW - 1;
    localparam int NS = obct_pkg::PIPE_STAGES;
    localparam int TW = obct_pkg::TRIG_WIDTH;

    localparam int O_ACX = 0;
    localparam int O_ACY = O_ACX + CW;
    localparam int O_AHX = O_ACY + CW;
    localparam int O_AHY = O_AHX + HS;
    localparam int O_AAN = O_AHY + HS;
    localparam int O_BCX = O_AAN + AW;
    localparam int O_BCY = O_BCX + CW;
    localparam int O_BHX = O_BCY + CW;
    localparam int O_BHY = O_BHX + HS;
    localparam int O_BAN = O_BHY + HS;
    localparam int O_RAD = O_BAN + AW;

    localparam int SIDE_W = 1 + 2 * (CW + 1) + 5 * HS;

    logic en;
    logic [NS-1:0] vld_reg, vld_next;

    assign en       = !vld_reg[NS-1] || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = vld_reg[NS-1];
    assign vld_next = {vld_reg[NS-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Input stage: center difference and field capture.
    logic signed [CW-1:0] acx, acy, bcx, bcy;
    logic signed [CW:0] dx_reg, dy_reg;
    logic [HS-1:0] ahx_reg, ahy_reg, bhx_reg, bhy_reg, rad_reg;
    logic [AW-1:0] aan_reg, ban_reg;
    logic mode_reg;

    assign acx = s_tdata[O_ACX +: CW];
    assign acy = s_tdata[O_ACY +: CW];
    assign bcx = s_tdata[O_BCX +: CW];
    assign bcy = s_tdata[O_BCY +: CW];

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= (CW+1)'(bcx) - (CW+1)'(acx);
            dy_reg   <= (CW+1)'(bcy) - (CW+1)'(acy);
            ahx_reg  <= s_tdata[O_AHX +: HS];
            ahy_reg  <= s_tdata[O_AHY +: HS];
            bhx_reg  <= s_tdata[O_BHX +: HS];
            bhy_reg  <= s_tdata[O_BHY +: HS];
            rad_reg  <= s_tdata[O_RAD +: HS];
            aan_reg  <= s_tdata[O_AAN +: AW];
            ban_reg  <= s_tdata[O_BAN +: AW];
            mode_reg <= s_tuser;
        end
    end

    logic signed [TW-1:0] cos_a, sin_a, cos_b, sin_b;

    obct_cordic #(.ANGLE_WIDTH(AW)) u_cordic_a (
        .aclk(aclk), .en(en), .angle(aan_reg), .cos_out(cos_a), .sin_out(sin_a)
    );

    obct_cordic #(.ANGLE_WIDTH(AW)) u_cordic_b (
        .aclk(aclk), .en(en), .angle(ban_reg), .cos_out(cos_b), .sin_out(sin_b)
    );

    logic [SIDE_W-1:0] side_in, side_out;
    logic mode_d;
    logic signed [CW:0] dx_d, dy_d;
    logic [HS-1:0] ahx_d, ahy_d, bhx_d, bhy_d, rad_d;

    assign side_in = {mode_reg, dx_reg, dy_reg, ahx_reg, ahy_reg, bhx_reg, bhy_reg, rad_reg};
    assign {mode_d, dx_d, dy_d, ahx_d, ahy_d, bhx_d, bhy_d, rad_d} = side_out;

    obct_delay #(.WIDTH(SIDE_W), .DEPTH(obct_pkg::CORDIC_STAGES)) u_delay (
        .aclk(aclk), .en(en), .din(side_in), .dout(side_out)
    );

    logic collide;

    obct_test #(.COORD_WIDTH(CW)) u_test (
        .aclk(aclk), .en(en), .mode(mode_d), .dx(dx_d), .dy(dy_d),
        .a_half_x(ahx_d), .a_half_y(ahy_d), .b_half_x(bhx_d), .b_half_y(bhy_d),
        .radius(rad_d), .cos_a(cos_a), .sin_a(sin_a), .cos_b(cos_b), .sin_b(sin_b),
        .collide(collide)
    );

    assign m_tdata = {7'b0, collide};

endmodule

// File: hw/rtl/obct_delay.sv
// Enabled shift line that carries side data alongside the CORDIC pipeline.
module obct_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: hw/rtl/obct_cordic.sv
// Pipelined CORDIC giving Q1.15 cosine and sine of a binary angle.
module obct_cordic #(
    parameter int ANGLE_WIDTH = obct_pkg::ANGLE_WIDTH
) (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic [ANGLE_WIDTH-1:0]                   angle,
    output logic signed [obct_pkg::TRIG_WIDTH-1:0]   cos_out,
    output logic signed [obct_pkg::TRIG_WIDTH-1:0]   sin_out
);

    localparam int XW = obct_pkg::CORDIC_XW;
    localparam int ZW = obct_pkg::CORDIC_ZW;
    localparam int N  = obct_pkg::CORDIC_ITERS;
    localparam int TW = obct_pkg::TRIG_WIDTH;

    logic [ZW-1:0] a32;
    assign a32 = {angle, (ZW - ANGLE_WIDTH)'(0)};

    logic signed [XW-1:0] x_reg [1:N];
    logic signed [XW-1:0] y_reg [1:N];
    logic signed [ZW-1:0] z_reg [1:N];
    logic [1:0]           q_reg [1:N];

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [XW-1:0] xi, yi;
        logic signed [ZW-1:0] zi;
        logic [1:0]           qi;
        if (i == 0) begin : g_first
            assign xi = obct_pkg::CORDIC_X0;
            assign yi = '0;
            assign zi = {2'b00, a32[ZW-3:0]};
            assign qi = a32[ZW-1:ZW-2];
        end else begin : g_next
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign qi = q_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!zi[ZW-1]) begin
                    x_reg[i+1] <= xi - (yi >>> i);
                    y_reg[i+1] <= yi + (xi >>> i);
                    z_reg[i+1] <= zi - obct_pkg::cordic_atan(4'(i));
                end else begin
                    x_reg[i+1] <= xi + (yi >>> i);
                    y_reg[i+1] <= yi - (xi >>> i);
                    z_reg[i+1] <= zi + obct_pkg::cordic_atan(4'(i));
                end
                q_reg[i+1] <= qi;
            end
        end
    end

    logic signed [XW-1:0] xc, yc;
    logic signed [TW-1:0] xs, ys;
    logic signed [TW-1:0] cos_next, sin_next, cos_reg, sin_reg;

    always_comb begin
        if (x_reg[N] > obct_pkg::TRIG_MAX) begin
            xc = obct_pkg::TRIG_MAX;
        end else if (x_reg[N] < -obct_pkg::TRIG_MAX) begin
            xc = -obct_pkg::TRIG_MAX;
        end else begin
            xc = x_reg[N];
        end
        if (y_reg[N] > obct_pkg::TRIG_MAX) begin
            yc = obct_pkg::TRIG_MAX;
        end else if (y_reg[N] < -obct_pkg::TRIG_MAX) begin
            yc = -obct_pkg::TRIG_MAX;
        end else begin
            yc = y_reg[N];
        end
        xs = xc[TW-1:0];
        ys = yc[TW-1:0];
        unique case (q_reg[N])
            obct_pkg::QUAD_0: begin cos_next = xs;  sin_next = ys;  end
            obct_pkg::QUAD_1: begin cos_next = -ys; sin_next = xs;  end
            obct_pkg::QUAD_2: begin cos_next = -xs; sin_next = -ys; end
            default:          begin cos_next = ys;  sin_next = -xs; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// File: hw/rtl/obct_test.sv
// Five-stage projection and clamp datapath that decides the collide bit.
module obct_test #(
    parameter int COORD_WIDTH = obct_pkg::COORD_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic                                   mode,
    input  logic signed [COORD_WIDTH:0]            dx,
    input  logic signed [COORD_WIDTH:0]            dy,
    input  logic [COORD_WIDTH-2:0]                 a_half_x,
    input  logic [COORD_WIDTH-2:0]                 a_half_y,
    input  logic [COORD_WIDTH-2:0]                 b_half_x,
    input  logic [COORD_WIDTH-2:0]                 b_half_y,
    input  logic [COORD_WIDTH-2:0]                 radius,
    input  logic signed [obct_pkg::TRIG_WIDTH-1:0] cos_a,
    input  logic signed [obct_pkg::TRIG_WIDTH-1:0] sin_a,
    input  logic signed [obct_pkg::TRIG_WIDTH-1:0] cos_b,
    input  logic signed [obct_pkg::TRIG_WIDTH-1:0] sin_b,
    output logic                                   collide
);

    localparam int CW = COORD_WIDTH;
    localparam int HS = CW - 1;         // half size width
    localparam int PW = CW + 17;        // coordinate times trig
    localparam int SW = PW + 1;         // sum of two such products
    localparam int LW = SW - 15;        // local coordinate after rounding
    localparam int EW = LW + 1;         // distance outside the box
    localparam int MW = 17;             // rounded axis dot magnitude
    localparam int HW = HS + MW;        // half size times magnitude
    localparam int DW = 34;             // axis dot before rounding

    function automatic logic [MW-1:0] dot_mag(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = (v + DW'(16384)) >>> 15;
        if (r[DW-1]) begin
            r = -r;
        end
        return r[MW-1:0];
    endfunction

    // Stage 1: products.
    logic signed [31:0] ca2_reg, sa2_reg, cb2_reg, sb2_reg;
    logic signed [31:0] cacb_reg, sasb_reg, casb_reg, sacb_reg;
    logic signed [PW-1:0] cadx_reg, sady_reg, sadx_reg, cady_reg;
    logic signed [PW-1:0] cbdx_reg, sbdy_reg, sbdx_reg, cbdy_reg;
    logic [HS-1:0] ahx1_reg, ahy1_reg, bhx1_reg, bhy1_reg, rad1_reg;
    logic mode1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ca2_reg  <= 32'(cos_a) * 32'(cos_a);
            sa2_reg  <= 32'(sin_a) * 32'(sin_a);
            cb2_reg  <= 32'(cos_b) * 32'(cos_b);
            sb2_reg  <= 32'(sin_b) * 32'(sin_b);
            cacb_reg <= 32'(cos_a) * 32'(cos_b);
            sasb_reg <= 32'(sin_a) * 32'(sin_b);
            casb_reg <= 32'(cos_a) * 32'(sin_b);
            sacb_reg <= 32'(sin_a) * 32'(cos_b);
            cadx_reg <= PW'(cos_a) * PW'(dx);
            sady_reg <= PW'(sin_a) * PW'(dy);
            sadx_reg <= PW'(sin_a) * PW'(dx);
            cady_reg <= PW'(cos_a) * PW'(dy);
            cbdx_reg <= PW'(cos_b) * PW'(dx);
            sbdy_reg <= PW'(sin_b) * PW'(dy);
            sbdx_reg <= PW'(sin_b) * PW'(dx);
            cbdy_reg <= PW'(cos_b) * PW'(dy);
            ahx1_reg <= a_half_x;
            ahy1_reg <= a_half_y;
            bhx1_reg <= b_half_x;
            bhy1_reg <= b_half_y;
            rad1_reg <= radius;
            mode1_reg <= mode;
        end
    end

    // Stage 2: axis dots rounded to Q15, projected center distances.
    logic signed [SW-1:0] pa0, pa1, pb0, pb1;
    logic signed [SW-1:0] lx_full, ly_full;
    logic [MW-1:0] ma_reg, mb_reg, mc_reg, md_reg, mdn_reg;
    logic [SW-1:0] pd_reg [0:3];
    logic signed [LW-1:0] lx_reg, ly_reg;
    logic [HS-1:0] ahx2_reg, ahy2_reg, bhx2_reg, bhy2_reg, rad2_reg;
    logic mode2_reg;

    assign pa0 = SW'(cadx_reg) + SW'(sady_reg);
    assign pa1 = SW'(cady_reg) - SW'(sadx_reg);
    assign pb0 = SW'(cbdx_reg) + SW'(sbdy_reg);
    assign pb1 = SW'(cbdy_reg) - SW'(sbdx_reg);
    assign lx_full = (pa0 + SW'(16384)) >>> 15;
    assign ly_full = (pa1 + SW'(16384)) >>> 15;

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg  <= dot_mag(DW'(ca2_reg) + DW'(sa2_reg));
            mb_reg  <= dot_mag(DW'(cb2_reg) + DW'(sb2_reg));
            mc_reg  <= dot_mag(DW'(cacb_reg) + DW'(sasb_reg));
            md_reg  <= dot_mag(DW'(sacb_reg) - DW'(casb_reg));
            mdn_reg <= dot_mag(DW'(casb_reg) - DW'(sacb_reg));
            pd_reg[0] <= pa0[SW-1] ? SW'(-pa0) : SW'(pa0);
            pd_reg[1] <= pa1[SW-1] ? SW'(-pa1) : SW'(pa1);
            pd_reg[2] <= pb0[SW-1] ? SW'(-pb0) : SW'(pb0);
            pd_reg[3] <= pb1[SW-1] ? SW'(-pb1) : SW'(pb1);
            lx_reg <= lx_full[LW-1:0];
            ly_reg <= ly_full[LW-1:0];
            ahx2_reg <= ahx1_reg;
            ahy2_reg <= ahy1_reg;
            bhx2_reg <= bhx1_reg;
            bhy2_reg <= bhy1_reg;
            rad2_reg <= rad1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // Stage 3: projected half extents per axis, circle clamp.
    logic [HW-1:0] ra_reg [0:3][0:1];
    logic [HW-1:0] rb_reg [0:3][0:1];
    logic [SW-1:0] pd3_reg [0:3];
    logic signed [EW-1:0] ex_next, ey_next, ex_reg, ey_reg;
    logic signed [EW-1:0] ahx_s, ahy_s;
    logic [HS-1:0] rad3_reg;
    logic mode3_reg;

    assign ahx_s = EW'(ahx2_reg);
    assign ahy_s = EW'(ahy2_reg);

    always_comb begin
        if (EW'(lx_reg) > ahx_s) begin
            ex_next = EW'(lx_reg) - ahx_s;
        end else if (EW'(lx_reg) < -ahx_s) begin
            ex_next = EW'(lx_reg) + ahx_s;
        end else begin
            ex_next = '0;
        end
        if (EW'(ly_reg) > ahy_s) begin
            ey_next = EW'(ly_reg) - ahy_s;
        end else if (EW'(ly_reg) < -ahy_s) begin
            ey_next = EW'(ly_reg) + ahy_s;
        end else begin
            ey_next = '0;
        end
    end

    // Cross terms of one box's own two axes are exactly zero and drop out.
    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg[0][0] <= HW'(ahx2_reg) * HW'(ma_reg);
            ra_reg[0][1] <= '0;
            rb_reg[0][0] <= HW'(bhx2_reg) * HW'(mc_reg);
            rb_reg[0][1] <= HW'(bhy2_reg) * HW'(md_reg);
            ra_reg[1][0] <= '0;
            ra_reg[1][1] <= HW'(ahy2_reg) * HW'(ma_reg);
            rb_reg[1][0] <= HW'(bhx2_reg) * HW'(mdn_reg);
            rb_reg[1][1] <= HW'(bhy2_reg) * HW'(mc_reg);
            ra_reg[2][0] <= HW'(ahx2_reg) * HW'(mc_reg);
            ra_reg[2][1] <= HW'(ahy2_reg) * HW'(mdn_reg);
            rb_reg[2][0] <= HW'(bhx2_reg) * HW'(mb_reg);
            rb_reg[2][1] <= '0;
            ra_reg[3][0] <= HW'(ahx2_reg) * HW'(md_reg);
            ra_reg[3][1] <= HW'(ahy2_reg) * HW'(mc_reg);
            rb_reg[3][0] <= '0;
            rb_reg[3][1] <= HW'(bhy2_reg) * HW'(mb_reg);
            for (int k = 0; k < 4; k++) begin
                pd3_reg[k] <= pd_reg[k];
            end
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            rad3_reg <= rad2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    // Stage 4: separation per axis, circle squares.
    logic [3:0] sep_reg;
    logic far_reg, mode4_reg;
    logic [2*CW-1:0] exsq_reg, eysq_reg;
    logic [2*HS-1:0] radsq_reg;
    logic [EW-1:0] ex_abs, ey_abs;
    logic signed [CW-1:0] ex_n, ey_n;

    assign ex_abs = ex_reg[EW-1] ? EW'(-ex_reg) : EW'(ex_reg);
    assign ey_abs = ey_reg[EW-1] ? EW'(-ey_reg) : EW'(ey_reg);
    // Only used when both distances are within the radius, so they fit.
    assign ex_n = ex_reg[CW-1:0];
    assign ey_n = ey_reg[CW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                sep_reg[k] <= pd3_reg[k] > (SW'(ra_reg[k][0]) + SW'(ra_reg[k][1])
                                          + SW'(rb_reg[k][0]) + SW'(rb_reg[k][1]));
            end
            far_reg   <= (ex_abs > EW'(rad3_reg)) || (ey_abs > EW'(rad3_reg));
            exsq_reg  <= (2*CW)'(ex_n) * (2*CW)'(ex_n);
            eysq_reg  <= (2*CW)'(ey_n) * (2*CW)'(ey_n);
            radsq_reg <= (2*HS)'(rad3_reg) * (2*HS)'(rad3_reg);
            mode4_reg <= mode3_reg;
        end
    end

    // Stage 5: final decision.
    logic collide_next, collide_reg;

    always_comb begin
        if (mode4_reg) begin
            collide_next = !far_reg &&
                ((2*CW+1)'(exsq_reg) + (2*CW+1)'(eysq_reg) <= (2*CW+1)'(radsq_reg));
        end else begin
            collide_next = ~|sep_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            collide_reg <= collide_next;
        end
    end

    assign collide = collide_reg;

endmodule
